// File: rtl/cce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_pkg: shared types and constants of the cheat code engine
// Command, code type, status and queue item definitions used by all modules.
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int ADDR_BITS = 16;
   localparam int MEM_SIZE  = 1 << ADDR_BITS;
   localparam int CODE_ADDR_BITS = 21;
   localparam int TYPE_SHIFT = 24;

   // request commands
   localparam logic [1:0] CMD_CODE   = 2'd0;
   localparam logic [1:0] CMD_MEM_WR = 2'd1;
   localparam logic [1:0] CMD_MEM_RD = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_AWAIT   = 2'd1;
   localparam logic [1:0] ST_SKIPPED = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // pending pair kinds
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_SLIDE = 2'd1;
   localparam logic [1:0] PEND_COPY  = 2'd2;

   // code type bytes
   localparam logic [7:0] TYP_W8    = 8'h30;
   localparam logic [7:0] TYP_W16   = 8'h80;
   localparam logic [7:0] TYP_ADD16 = 8'h10;
   localparam logic [7:0] TYP_SUB16 = 8'h11;
   localparam logic [7:0] TYP_ADD8  = 8'h20;
   localparam logic [7:0] TYP_SUB8  = 8'h21;
   localparam logic [7:0] TYP_SLIDE = 8'h50;
   localparam logic [7:0] TYP_COPY  = 8'hC2;
   localparam logic [7:0] TYP_C8_EQ = 8'hE0;
   localparam logic [7:0] TYP_C8_NE = 8'hE1;
   localparam logic [7:0] TYP_C8_LT = 8'hE2;
   localparam logic [7:0] TYP_C8_GT = 8'hE3;
   localparam logic [7:0] TYP_C16_EQ = 8'hD0;
   localparam logic [7:0] TYP_C16_NE = 8'hD1;
   localparam logic [7:0] TYP_C16_LT = 8'hD2;
   localparam logic [7:0] TYP_C16_GT = 8'hD3;

   // compare selects (low two bits of the compare type)
   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_NE = 2'd1;
   localparam logic [1:0] CMP_LT = 2'd2;
   localparam logic [1:0] CMP_GT = 2'd3;

   typedef enum logic [1:0] {
      K_CODE, K_MWR, K_MRD, K_BAD
   } kind_type;

   typedef enum logic [3:0] {
      OP_W8, OP_W16, OP_ADD16, OP_SUB16, OP_ADD8, OP_SUB8,
      OP_SLIDE, OP_COPY, OP_CMP8, OP_CMP16, OP_UNK
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_MRD, S_RD_LO, S_RD_HI, S_CALC,
      S_WR_HI, S_SLIDE, S_SLIDE_HI, S_CP_RD, S_CP_WR, S_RESP
   } state_type;

   typedef struct packed {
      kind_type                  kind;
      op_type                    op;
      logic                      wide;
      logic [1:0]                cmp_sel;
      logic [CODE_ADDR_BITS-1:0] addr;
      logic [15:0]               value;
      logic                      last;
      logic [ADDR_BITS-1:0]      maddr;
      logic [7:0]                mdata;
   } item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

endpackage
`default_nettype wire

// File: rtl/cce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_front: request intake and classification
// Decodes each request into a queue item and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module cce_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_command,
   input  wire logic [31:0]                   req_code_word,
   input  wire logic [15:0]                   req_code_value,
   input  wire logic                          req_last_of_group,
   input  wire logic [cce_pkg::CODE_ADDR_BITS-1:0] req_mem_address,
   input  wire logic [7:0]                    req_mem_data,
   input  wire cce_pkg::back_stat_type        bstat,
   output logic                               q_valid,
   output cce_pkg::item_type                  q_item
);
   import cce_pkg::*;

   item_type   dec;
   logic [7:0] code_type;
   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign code_type = req_code_word[TYPE_SHIFT +: 8];

   always_comb begin
      dec         = '0;
      dec.addr    = req_code_word[CODE_ADDR_BITS-1:0];
      dec.value   = req_code_value;
      dec.last    = req_last_of_group;
      dec.maddr   = req_mem_address[ADDR_BITS-1:0];
      dec.mdata   = req_mem_data;
      dec.cmp_sel = code_type[1:0];
      unique case (req_command)
         CMD_CODE:   dec.kind = K_CODE;
         CMD_MEM_WR: dec.kind = K_MWR;
         CMD_MEM_RD: dec.kind = K_MRD;
         default:    dec.kind = K_BAD;
      endcase
      unique case (code_type) inside
         TYP_W8:    dec.op = OP_W8;
         TYP_W16:   dec.op = OP_W16;
         TYP_ADD16: dec.op = OP_ADD16;
         TYP_SUB16: dec.op = OP_SUB16;
         TYP_ADD8:  dec.op = OP_ADD8;
         TYP_SUB8:  dec.op = OP_SUB8;
         TYP_SLIDE: dec.op = OP_SLIDE;
         TYP_COPY:  dec.op = OP_COPY;
         TYP_C8_EQ, TYP_C8_NE, TYP_C8_LT, TYP_C8_GT:     dec.op = OP_CMP8;
         TYP_C16_EQ, TYP_C16_NE, TYP_C16_LT, TYP_C16_GT: dec.op = OP_CMP16;
         default:   dec.op = OP_UNK;
      endcase
      dec.wide = (dec.op == OP_W16) || (dec.op == OP_ADD16) ||
                 (dec.op == OP_SUB16) || (dec.op == OP_CMP16);
   end

   assign req_ready = (cnt_ff != 2'd2) && !bstat.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = bstat.pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, bstat.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

// File: rtl/cce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_back: code execution sequencer
// Owns the target memory and the pair/skip state; runs one item at a time.
// ----------------------------------------------------------------------------
module cce_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire cce_pkg::item_type      q_item,
   output cce_pkg::back_stat_type      bstat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_read_data,
   output logic [1:0]                  rsp_status
);
   import cce_pkg::*;

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic [1:0]  pend_ff, pend_in;
   logic [CODE_ADDR_BITS-1:0] hadr_ff, hadr_in;
   logic [15:0] hval_ff, hval_in;
   logic        skip_ff, skip_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in, src_ff, src_in, clr_ff, clr_in;
   logic [15:0] val_ff, val_in, cnt_ff, cnt_in;
   logic [7:0]  lo_ff, lo_in, hi_ff, hi_in, data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [7:0]  mem [MEM_SIZE];
   logic [7:0]  mem_q_ff;
   logic        mem_we;
   logic [ADDR_BITS-1:0] mem_wa, mem_ra;
   logic [7:0]  mem_wd;

   logic        out_free, pair_ok, fail;
   logic [15:0] opa, opb, sum, dif, res, vstep;
   logic [ADDR_BITS-1:0] astep;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pair_ok  = (item_ff.op == OP_W8) || (item_ff.op == OP_W16);
   assign opa   = item_ff.wide ? {mem_q_ff, lo_ff} : {8'h00, mem_q_ff};
   assign opb   = item_ff.wide ? item_ff.value : {8'h00, item_ff.value[7:0]};
   assign sum   = opa + opb;
   assign dif   = opa - opb;
   assign res   = ((item_ff.op == OP_ADD8) || (item_ff.op == OP_ADD16)) ? sum : dif;
   assign vstep = {{8{hval_ff[7]}}, hval_ff[7:0]};
   assign astep = {{(ADDR_BITS-8){hadr_ff[7]}}, hadr_ff[7:0]};

   always_comb begin
      case (item_ff.cmp_sel)
         CMP_EQ:  fail = (opa != opb);
         CMP_NE:  fail = (opa == opb);
         CMP_LT:  fail = (opa >= opb);
         default: fail = (opa <= opb);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE:  if (q_valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (item_ff.kind)
               K_MRD: state_in = S_MRD;
               K_CODE: begin
                  if (pend_ff == PEND_SLIDE) begin
                     state_in = pair_ok ? S_SLIDE : S_RESP;
                  end else if (pend_ff != PEND_NONE) begin
                     state_in = S_CP_RD;
                  end else if (skip_ff) begin
                     state_in = S_RESP;
                  end else begin
                     case (item_ff.op)
                        OP_W16: state_in = S_WR_HI;
                        OP_ADD8, OP_SUB8, OP_CMP8,
                        OP_ADD16, OP_SUB16, OP_CMP16: state_in = S_RD_LO;
                        default: state_in = S_RESP;
                     endcase
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_MRD:   state_in = S_RESP;
         S_RD_LO: state_in = item_ff.wide ? S_RD_HI : S_CALC;
         S_RD_HI: state_in = S_CALC;
         S_CALC:  state_in = (item_ff.wide && item_ff.op != OP_CMP16) ? S_WR_HI : S_RESP;
         S_WR_HI: state_in = S_RESP;
         S_SLIDE: begin
            if (cnt_ff == 16'd0) state_in = S_RESP;
            else if (item_ff.wide) state_in = S_SLIDE_HI;
         end
         S_SLIDE_HI: state_in = S_SLIDE;
         S_CP_RD: state_in = (cnt_ff == 16'd0) ? S_RESP : S_CP_WR;
         S_CP_WR: state_in = S_CP_RD;
         S_RESP:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in = item_ff;   pend_in = pend_ff;   hadr_in = hadr_ff;
      hval_in = hval_ff;   skip_in = skip_ff;   addr_in = addr_ff;
      src_in  = src_ff;    clr_in  = clr_ff;    val_in  = val_ff;
      cnt_in  = cnt_ff;    lo_in   = lo_ff;     hi_in   = hi_ff;
      data_in = data_ff;   status_in = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_we = 1'b0;  mem_wa = addr_ff;  mem_wd = 8'h00;  mem_ra = addr_ff;
      bstat.pop = 1'b0;
      bstat.clearing = (state_ff == S_CLEAR);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (q_valid) begin
               bstat.pop = 1'b1;
               item_in   = q_item;
            end
         end
         S_DECODE: begin
            status_in = ST_DONE;
            data_in   = 8'h00;
            addr_in   = item_ff.addr[ADDR_BITS-1:0];
            unique case (item_ff.kind)
               K_MWR: begin
                  mem_we = 1'b1;
                  mem_wa = item_ff.maddr;
                  mem_wd = item_ff.mdata;
               end
               K_MRD: mem_ra = item_ff.maddr;
               K_BAD: status_in = ST_IGNORED;
               default: begin
                  if (pend_ff != PEND_NONE) begin
                     pend_in = PEND_NONE;
                     val_in  = item_ff.value;
                     if (pend_ff == PEND_SLIDE) begin
                        cnt_in = {8'h00, hadr_ff[15:8]};
                        if (!pair_ok) status_in = ST_IGNORED;
                     end else begin
                        cnt_in = hval_ff;
                        src_in = hadr_ff[ADDR_BITS-1:0];
                     end
                  end else if (skip_ff) begin
                     skip_in   = 1'b0;
                     status_in = ST_SKIPPED;
                  end else begin
                     case (item_ff.op)
                        OP_W8, OP_W16: begin
                           mem_we = 1'b1;
                           mem_wa = item_ff.addr[ADDR_BITS-1:0];
                           mem_wd = item_ff.value[7:0];
                           hi_in  = item_ff.value[15:8];
                        end
                        OP_SLIDE, OP_COPY: begin
                           pend_in   = (item_ff.op == OP_SLIDE) ? PEND_SLIDE : PEND_COPY;
                           hadr_in   = item_ff.addr;
                           hval_in   = item_ff.value;
                           status_in = ST_AWAIT;
                        end
                        OP_UNK: status_in = ST_IGNORED;
                        default: ;
                     endcase
                  end
               end
            endcase
         end
         S_MRD: data_in = mem_q_ff;
         S_RD_LO: mem_ra = addr_ff;
         S_RD_HI: begin
            mem_ra = addr_ff + 1'b1;
            lo_in  = mem_q_ff;
         end
         S_CALC: begin
            if ((item_ff.op == OP_CMP8) || (item_ff.op == OP_CMP16)) begin
               skip_in = skip_ff | fail;
            end else begin
               mem_we = 1'b1;
               mem_wd = res[7:0];
               hi_in  = res[15:8];
            end
         end
         S_WR_HI: begin
            mem_we = 1'b1;
            mem_wa = addr_ff + 1'b1;
            mem_wd = hi_ff;
         end
         S_SLIDE: begin
            if (cnt_ff != 16'd0) begin
               mem_we = 1'b1;
               mem_wd = val_ff[7:0];
               hi_in  = val_ff[15:8];
               if (!item_ff.wide) begin
                  addr_in = addr_ff + astep;
                  val_in  = val_ff + vstep;
                  cnt_in  = cnt_ff - 16'd1;
               end
            end
         end
         S_SLIDE_HI: begin
            mem_we  = 1'b1;
            mem_wa  = addr_ff + 1'b1;
            mem_wd  = hi_ff;
            addr_in = addr_ff + astep;
            val_in  = val_ff + vstep;
            cnt_in  = cnt_ff - 16'd1;
         end
         S_CP_RD: mem_ra = src_ff;
         S_CP_WR: begin
            mem_we  = 1'b1;
            mem_wd  = mem_q_ff;
            src_in  = src_ff + 1'b1;
            addr_in = addr_ff + 1'b1;
            cnt_in  = cnt_ff - 16'd1;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = data_ff;
               rsp_status_in = status_ff;
               if (item_ff.kind == K_CODE && item_ff.last) begin
                  if (pend_ff != PEND_NONE) rsp_status_in = ST_DONE;
                  pend_in = PEND_NONE;
                  skip_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= PEND_NONE;
         hadr_ff      <= '0;
         hval_ff      <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         hadr_ff      <= hadr_in;
         hval_ff      <= hval_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      addr_ff       <= addr_in;
      src_ff        <= src_in;
      val_ff        <= val_in;
      cnt_ff        <= cnt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
`default_nettype wire

// File: rtl/cheat_code_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cheat_code_engine: cheat code interpreter over an internal byte memory
// Applies cheat code words and serves byte write/read commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one transfer carries a command, a code word and
//    value, the end-of-group flag and a memory address/data byte.
//  - Response channel (rsp_*): exactly one transfer per request, in order,
//    with the read byte (zero unless a memory read) and a status code.
//  - After reset the 64 KiB memory is zeroed by a clearing pass; req_ready
//    stays low until it ends.
//  - Requests are held in a two-entry queue; the sequencer runs one at a time
//    on a byte memory with one read and one write port, so latency is set by
//    memory accesses: an 8-bit slide writes one byte per element, a 16-bit
//    slide two bytes per element, and a copy reads then writes each byte.
//  - A finished response waits in the output register; while the receiver
//    stalls the queue keeps taking up to two more requests, then backs up.
// ----------------------------------------------------------------------------
module cheat_code_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_code_word,
   input  wire logic [15:0] req_code_value,
   input  wire logic        req_last_of_group,
   input  wire logic [20:0] req_mem_address,
   input  wire logic [7:0]  req_mem_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_status
);
   import cce_pkg::*;

   back_stat_type bstat;
   logic          q_valid;
   item_type      q_item;

   // intake and classification
   cce_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_code_word     (req_code_word),
      .req_code_value    (req_code_value),
      .req_last_of_group (req_last_of_group),
      .req_mem_address   (req_mem_address),
      .req_mem_data      (req_mem_data),
      .bstat             (bstat),
      .q_valid           (q_valid),
      .q_item            (q_item)
   );

   // execution against the memory
   cce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .bstat         (bstat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status)
   );

   // hold off requests in the cycle after reset: clearing has begun
   a_clear_blocks: assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request accepted during memory clear");

   // pop only from a non-empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      bstat.pop |-> q_valid)
      else $error("pop from empty queue");

   // no execution while clearing
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      bstat.clearing |-> !bstat.pop)
      else $error("item popped during clear");

   // only a memory read returns data, and it always reports done
   a_data_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_data != 8'h00) |-> rsp_status == ST_DONE)
      else $error("read data with non-done status");

endmodule
`default_nettype wire
